### rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// shared constants, codes and controller/datapath types of the heap allocator
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WORD_AW    = $clog2(HEAP_WORDS);
  localparam int PTR_W      = $clog2(HEAP_BYTES) + 2;
  localparam int DATA_W     = 32;
  localparam int CHUNK_W    = 17;
  localparam int REQ_W      = 16;
  localparam int ADDR_W     = 16;
  localparam int STAT_W     = 2;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);
  localparam logic [PTR_W-1:0]   HEAP_LIM    = PTR_W'(HEAP_BYTES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM  = 2'd2;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_INIT0, OP_INIT1, OP_INIT2, OP_INIT3,
    OP_GSIZE_CHUNK, OP_GSIZE_EXT, OP_G1, OP_G2, OP_G3,
    OP_WALK_START, OP_RD_HDR, OP_TAKE, OP_STEP,
    OP_R1, OP_R2, OP_RD_PFT, OP_M_PREV, OP_M_NEXT,
    OP_MA1, OP_MA2, OP_MB1, OP_MB2, OP_MC1, OP_MC2,
    OP_P1, OP_P2, OP_P3, OP_P4, OP_ST_ZERO, OP_ST_OOM, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } bta_cmd_t;

  typedef struct packed {
    logic ready;
    logic cmd_free;
    logic req_zero;
    logic p_lt_brk;
    logic rsize_zero;
    logic ralloc;
    logic fit;
    logic match;
    logic grow_ok;
    logic split;
    logic pa;
    logic na;
  } bta_stat_t;

  // boundary tag word: size in bytes with the allocated flag in bit 0
  function automatic logic [DATA_W-1:0] make_tag(logic [PTR_W-1:0] sz, logic a);
    return {{(DATA_W-PTR_W){1'b0}}, sz[PTR_W-1:1], a};
  endfunction

endpackage

### rtl/boundary_tag_heap_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// first-fit heap allocator with boundary tags over a 64 KiB word memory
// ----------------------------------------------------------------------------
// items: one at a time; the block takes no new item until the last result is emitted,
//   and the work per item is set by the walk over the block list at one memory
//   read per block
// reset: synchronous, clears break and ready flag, chunk size back to 4096; heap
//   memory is not cleared, every tag is written before it is read
module boundary_tag_heap_allocator
  import bta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration: chunk size in bytes
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_wdata,
  // command items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [REQ_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]  block_addr,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  result_addr,
  output logic [STAT_W-1:0]  status
);

  bta_cmd_t  dcmd;
  bta_stat_t dstat;

  // sequencer: at most one micro-op per cycle toward the datapath
  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dcmd      (dcmd),
    .dstat     (dstat)
  );

  // heap memory, tag math and the output register
  bta_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .dcmd      (dcmd),
    .dstat     (dstat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (cmd),
    .in_req    (req_size),
    .in_addr   (block_addr),
    .res_out   (result_addr),
    .stat_out  (status)
  );

endmodule

### rtl/bta_ram.sv
// ----------------------------------------------------------------------------
// bta_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bta_datapath.sv
// ----------------------------------------------------------------------------
// bta_datapath
// heap memory, pointer and size registers, tag arithmetic and result register
// ----------------------------------------------------------------------------
module bta_datapath
  import bta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  bta_cmd_t           dcmd,
  output bta_stat_t          dstat,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_wdata,
  input  logic               in_cmd,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [ADDR_W-1:0]  in_addr,
  output logic [ADDR_W-1:0]  res_out,
  output logic [STAT_W-1:0]  stat_out
);

  logic [PTR_W-1:0]   brk;
  logic               ready;
  logic [CHUNK_W-1:0] chunk;
  logic               cmd_r;
  logic               req_zero;
  logic [ADDR_W-1:0]  addr_r;
  logic [PTR_W-1:0]   asize, gbytes, p, s, psz, nsz;
  logic               pa, na;
  logic [ADDR_W-1:0]  res;
  logic [STAT_W-1:0]  stat;

  logic [DATA_W-1:0]  rdata, wdata;
  logic [PTR_W-1:0]   waddr, raddr, rsize, place_sz, ext_max, req_up;
  logic               wr;

  assign rsize    = {rdata[PTR_W-1:3], 3'b000};
  assign place_sz = dstat.split ? asize : s;
  assign ext_max  = (asize > PTR_W'(chunk)) ? asize : PTR_W'(chunk);
  assign req_up   = (PTR_W'(in_req) + PTR_W'(15)) & ~PTR_W'(7);

  always_comb begin
    dstat.ready      = ready;
    dstat.cmd_free   = (cmd_r == CMD_FREE);
    dstat.req_zero   = req_zero;
    dstat.p_lt_brk   = p < brk;
    dstat.rsize_zero = (rsize == '0);
    dstat.ralloc     = rdata[0];
    dstat.fit        = asize <= rsize;
    dstat.match      = (p == PTR_W'(addr_r));
    dstat.grow_ok    = (gbytes != '0) && (gbytes <= HEAP_LIM - brk);
    dstat.split      = (s - asize) >= PTR_W'(16);
    dstat.pa         = pa;
    dstat.na         = na;
  end

  // memory address and data per operation
  always_comb begin
    wr    = 1'b1;
    waddr = p - PTR_W'(4);
    wdata = '0;
    raddr = p - PTR_W'(4);
    unique case (dcmd.op)
      OP_INIT0: begin waddr = PTR_W'(0);  wdata = '0; end
      OP_INIT1: begin waddr = PTR_W'(4);  wdata = make_tag(PTR_W'(8), 1'b1); end
      OP_INIT2: begin waddr = PTR_W'(8);  wdata = make_tag(PTR_W'(8), 1'b1); end
      OP_INIT3: begin waddr = PTR_W'(12); wdata = make_tag('0, 1'b1); end
      OP_G1: begin waddr = brk - PTR_W'(4); wdata = make_tag(gbytes, 1'b0); end
      OP_G2: begin waddr = p + s - PTR_W'(8); wdata = make_tag(s, 1'b0); end
      OP_G3: begin waddr = p + s - PTR_W'(4); wdata = make_tag('0, 1'b1); end
      OP_R1: begin waddr = p - PTR_W'(4); wdata = make_tag(s, 1'b0); end
      OP_R2: begin waddr = p + s - PTR_W'(8); wdata = make_tag(s, 1'b0); end
      OP_MA1: begin waddr = p - PTR_W'(4); wdata = make_tag(s + nsz, 1'b0); end
      OP_MA2: begin waddr = p + s - PTR_W'(8); wdata = make_tag(s, 1'b0); end
      OP_MB1: begin waddr = p + s - PTR_W'(8); wdata = make_tag(s + psz, 1'b0); end
      OP_MB2: begin waddr = p - psz - PTR_W'(4); wdata = make_tag(s + psz, 1'b0); end
      OP_MC1: begin
        waddr = p + s + nsz - PTR_W'(8);
        wdata = make_tag(s + psz + nsz, 1'b0);
      end
      OP_MC2: begin
        waddr = p - psz - PTR_W'(4);
        wdata = make_tag(s + psz + nsz, 1'b0);
      end
      OP_P1: begin waddr = p - PTR_W'(4); wdata = make_tag(place_sz, 1'b1); end
      OP_P2: begin waddr = p + place_sz - PTR_W'(8); wdata = make_tag(place_sz, 1'b1); end
      OP_P3: begin waddr = p + asize - PTR_W'(4); wdata = make_tag(s - asize, 1'b0); end
      OP_P4: begin waddr = p + s - PTR_W'(8); wdata = make_tag(s - asize, 1'b0); end
      OP_RD_PFT: begin wr = 1'b0; raddr = p - PTR_W'(8); end
      OP_M_PREV: begin wr = 1'b0; raddr = p + s - PTR_W'(4); end
      default: wr = 1'b0;
    endcase
  end

  bta_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (wr && (waddr[PTR_W-1:WORD_AW+2] == '0)),
    .waddr (waddr[WORD_AW+1:2]),
    .wdata (wdata),
    .raddr (raddr[WORD_AW+1:2]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      brk   <= '0;
      ready <= 1'b0;
      chunk <= CHUNK_RESET;
    end else begin
      if (cfg_we) begin
        chunk <= cfg_wdata;
      end
      unique case (dcmd.op)
        OP_LOAD: begin
          cmd_r    <= in_cmd;
          req_zero <= (in_req == '0);
          addr_r   <= in_addr;
          asize    <= (in_req <= REQ_W'(8)) ? PTR_W'(16) : req_up;
          res      <= '0;
          stat     <= ST_OK;
        end
        OP_INIT3: begin
          brk   <= PTR_W'(16);
          ready <= 1'b1;
        end
        OP_GSIZE_CHUNK: gbytes <= (PTR_W'(chunk) + PTR_W'(7)) & ~PTR_W'(7);
        OP_GSIZE_EXT:   gbytes <= (ext_max + PTR_W'(7)) & ~PTR_W'(7);
        OP_G1: begin
          p   <= brk;
          s   <= gbytes;
          brk <= brk + gbytes;
        end
        OP_WALK_START: p <= PTR_W'(8);
        OP_TAKE:       s <= rsize;
        OP_STEP:       p <= p + rsize;
        OP_M_PREV: begin
          pa  <= rdata[0];
          psz <= rsize;
        end
        OP_M_NEXT: begin
          na  <= rdata[0];
          nsz <= rsize;
        end
        OP_MA1: s <= s + nsz;
        OP_MB2: begin
          p <= p - psz;
          s <= s + psz;
        end
        OP_MC2: begin
          p <= p - psz;
          s <= s + psz + nsz;
        end
        OP_P2:      res  <= p[ADDR_W-1:0];
        OP_ST_ZERO: stat <= ST_ZERO;
        OP_ST_OOM:  stat <= ST_OOM;
        OP_EMIT: begin
          res_out  <= res;
          stat_out <= stat;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/bta_ctrl.sv
// ----------------------------------------------------------------------------
// bta_ctrl
// sequencer for init, first-fit walk, grow, coalesce, place and free
// ----------------------------------------------------------------------------
module bta_ctrl
  import bta_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output bta_cmd_t  dcmd,
  input  bta_stat_t dstat
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INIT1, S_INIT2, S_INIT3, S_GSETC, S_ZCHK,
    S_WCHK, S_WEVAL, S_GSETX, S_GROW, S_G2, S_G3, S_REL1, S_REL2,
    S_M1, S_M2, S_M3, S_MDEC, S_MA2, S_MB2, S_MC2, S_MEND,
    S_PLACE1, S_PLACE2, S_PLACE3, S_PLACE4, S_EMIT
  } state_t;

  typedef enum logic [1:0] {CTX_INIT, CTX_ALLOC, CTX_FREE} ctx_t;

  state_t state, state_next;
  ctx_t   ctx, ctx_next;
  logic   emit;

  assign in_stall = (state != S_IDLE);
  assign emit     = (dcmd.op == OP_EMIT);

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    dcmd.op    = OP_NOP;
    unique case (state)
      S_IDLE: if (in_valid) begin
        dcmd.op    = OP_LOAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (dstat.cmd_free) begin
          if (!dstat.ready) begin
            state_next = S_EMIT;
          end else begin
            dcmd.op    = OP_WALK_START;
            state_next = S_WCHK;
          end
        end else if (!dstat.ready) begin
          dcmd.op    = OP_INIT0;
          state_next = S_INIT1;
        end else begin
          state_next = S_ZCHK;
        end
      end
      S_INIT1: begin dcmd.op = OP_INIT1; state_next = S_INIT2; end
      S_INIT2: begin dcmd.op = OP_INIT2; state_next = S_INIT3; end
      S_INIT3: begin dcmd.op = OP_INIT3; state_next = S_GSETC; end
      S_GSETC: begin
        dcmd.op    = OP_GSIZE_CHUNK;
        ctx_next   = CTX_INIT;
        state_next = S_GROW;
      end
      S_ZCHK: begin
        if (dstat.req_zero) begin
          dcmd.op    = OP_ST_ZERO;
          state_next = S_EMIT;
        end else begin
          dcmd.op    = OP_WALK_START;
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!dstat.p_lt_brk) begin
          state_next = dstat.cmd_free ? S_EMIT : S_GSETX;
        end else begin
          dcmd.op    = OP_RD_HDR;
          state_next = S_WEVAL;
        end
      end
      S_WEVAL: begin
        if (dstat.rsize_zero) begin
          state_next = dstat.cmd_free ? S_EMIT : S_GSETX;
        end else if (!dstat.cmd_free) begin
          if (!dstat.ralloc && dstat.fit) begin
            dcmd.op    = OP_TAKE;
            state_next = S_PLACE1;
          end else begin
            dcmd.op    = OP_STEP;
            state_next = S_WCHK;
          end
        end else if (dstat.match) begin
          if (dstat.ralloc) begin
            dcmd.op    = OP_TAKE;
            state_next = S_REL1;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          dcmd.op    = OP_STEP;
          state_next = S_WCHK;
        end
      end
      S_GSETX: begin
        dcmd.op    = OP_GSIZE_EXT;
        ctx_next   = CTX_ALLOC;
        state_next = S_GROW;
      end
      S_GROW: begin
        if (dstat.grow_ok) begin
          dcmd.op    = OP_G1;
          state_next = S_G2;
        end else if (ctx == CTX_INIT) begin
          state_next = S_ZCHK;
        end else begin
          dcmd.op    = OP_ST_OOM;
          state_next = S_EMIT;
        end
      end
      S_G2: begin dcmd.op = OP_G2; state_next = S_G3; end
      S_G3: begin dcmd.op = OP_G3; state_next = S_M1; end
      S_REL1: begin dcmd.op = OP_R1; state_next = S_REL2; end
      S_REL2: begin
        dcmd.op    = OP_R2;
        ctx_next   = CTX_FREE;
        state_next = S_M1;
      end
      S_M1: begin dcmd.op = OP_RD_PFT; state_next = S_M2; end
      S_M2: begin dcmd.op = OP_M_PREV; state_next = S_M3; end
      S_M3: begin dcmd.op = OP_M_NEXT; state_next = S_MDEC; end
      S_MDEC: begin
        if (dstat.pa && dstat.na) begin
          state_next = S_MEND;
        end else if (dstat.pa) begin
          dcmd.op    = OP_MA1;
          state_next = S_MA2;
        end else if (dstat.na) begin
          dcmd.op    = OP_MB1;
          state_next = S_MB2;
        end else begin
          dcmd.op    = OP_MC1;
          state_next = S_MC2;
        end
      end
      S_MA2: begin dcmd.op = OP_MA2; state_next = S_MEND; end
      S_MB2: begin dcmd.op = OP_MB2; state_next = S_MEND; end
      S_MC2: begin dcmd.op = OP_MC2; state_next = S_MEND; end
      S_MEND: begin
        unique case (ctx)
          CTX_INIT:  state_next = S_ZCHK;
          CTX_ALLOC: state_next = S_PLACE1;
          default:   state_next = S_EMIT;
        endcase
      end
      S_PLACE1: begin dcmd.op = OP_P1; state_next = S_PLACE2; end
      S_PLACE2: begin
        dcmd.op    = OP_P2;
        state_next = dstat.split ? S_PLACE3 : S_EMIT;
      end
      S_PLACE3: begin dcmd.op = OP_P3; state_next = S_PLACE4; end
      S_PLACE4: begin dcmd.op = OP_P4; state_next = S_EMIT; end
      S_EMIT: if (!out_valid || !out_stall) begin
        dcmd.op    = OP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ctx       <= CTX_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ctx       <= ctx_next;
      out_valid <= emit || (out_valid && out_stall);
    end
  end

endmodule

### bench/heap_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_alloc_checker
// watches both channels of the heap allocator, predicts each result from its
// own boundary-tag heap image and compares field by field
// ----------------------------------------------------------------------------
module heap_alloc_checker
  import bta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               cmd,
  input  logic [REQ_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]  block_addr,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ADDR_W-1:0]  result_addr,
  input  logic [STAT_W-1:0]  status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] stat;
  } alloc_result_t;

  alloc_result_t result_q[$];
  logic [31:0]   mem [HEAP_WORDS];
  logic [31:0]   brk;
  logic          ready;
  logic [31:0]   chunk;

  function automatic logic [31:0] rd(logic [31:0] a);
    return (a >> 2) < HEAP_WORDS ? mem[a >> 2] : 32'd0;
  endfunction

  function automatic void wr(logic [31:0] a, logic [31:0] v);
    if ((a >> 2) < HEAP_WORDS) mem[a >> 2] = v;
  endfunction

  function automatic logic [31:0] sz(logic [31:0] a);
    return rd(a) & 32'hFFFF_FFF8;
  endfunction

  function automatic logic al(logic [31:0] a);
    return (rd(a) & 32'h1) != 32'd0;
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] s, nx, ps, ns;
    logic        pa, na;
    s  = sz(bp - 4);
    nx = bp + s;
    pa = al(bp - 8);
    na = al(nx - 4);
    if (pa && na) return bp;
    if (pa) begin
      s += sz(nx - 4);
      wr(bp - 4, s);
      wr(bp + s - 8, s);
      return bp;
    end
    ps = sz(bp - 8);
    if (na) begin
      wr(bp + s - 8, s + ps);
      wr(bp - ps - 4, s + ps);
      return bp - ps;
    end
    ns = sz(nx - 4);
    s  = s + ps + ns;
    wr(nx + ns - 8, s);
    wr(bp - ps - 4, s);
    return bp - ps;
  endfunction

  function automatic logic [31:0] extend(logic [31:0] bytes);
    logic [31:0] bp;
    bytes = (bytes + 7) & 32'hFFFF_FFF8;
    if (bytes == 0 || brk > HEAP_BYTES || bytes > HEAP_BYTES - brk) return 0;
    bp  = brk;
    brk = brk + bytes;
    wr(bp - 4, bytes);
    wr(bp + bytes - 8, bytes);
    wr(bp + bytes - 4, 32'h1);
    return coalesce(bp);
  endfunction

  function automatic void carve(logic [31:0] bp, logic [31:0] asz);
    logic [31:0] c;
    c = sz(bp - 4);
    if (c - asz >= 16) begin
      wr(bp - 4, asz | 1);
      wr(bp + asz - 8, asz | 1);
      bp += asz;
      wr(bp - 4, c - asz);
      wr(bp + c - asz - 8, c - asz);
    end else begin
      wr(bp - 4, c | 1);
      wr(bp + c - 8, c | 1);
    end
  endfunction

  function automatic alloc_result_t predict(logic c, logic [15:0] rq, logic [15:0] ba);
    alloc_result_t r;
    logic [31:0]   p, s, asz, bp, ext;
    r = '0;
    if (c == CMD_FREE) begin
      if (!ready) return r;
      p = 8;
      while (p < brk && sz(p - 4) != 0) begin
        s = sz(p - 4);
        if (p == ba) begin
          if (al(p - 4)) begin
            wr(p - 4, s);
            wr(p + s - 8, s);
            void'(coalesce(p));
          end
          break;
        end
        p += s;
      end
      return r;
    end
    if (!ready) begin
      // prologue, epilogue, then the first chunk
      brk = 16;
      wr(0, 0); wr(4, 9); wr(8, 9); wr(12, 1);
      ready = 1'b1;
      void'(extend(chunk));
    end
    if (rq == 0) begin
      r.stat = ST_ZERO;
      return r;
    end
    asz = (rq <= 8) ? 32'd16 : 8 * ((32'(rq) + 15) / 8);
    bp = 0;
    p  = 8;
    while (p < brk && sz(p - 4) != 0) begin
      s = sz(p - 4);
      if (!al(p - 4) && asz <= s) begin
        bp = p;
        break;
      end
      p += s;
    end
    if (bp == 0) begin
      ext = (asz > chunk) ? asz : chunk;
      bp  = extend(ext);
      if (bp == 0) begin
        r.stat = ST_OOM;
        return r;
      end
    end
    carve(bp, asz);
    r.addr = bp[15:0];
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst) begin
      brk   = 0;
      ready = 1'b0;
      chunk = 32'(CHUNK_RESET);
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) chunk = 32'(cfg_wdata);
      if (in_valid && !in_stall) result_q.push_back(predict(cmd, req_size, block_addr));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d", $time, result_addr, status);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e.addr !== result_addr || e.stat !== status) begin
            $display("%0t: mismatch expected addr=%h status=%0d actual addr=%h status=%0d",
                     $time, e.addr, e.stat, result_addr, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### bench/tb_boundary_tag_heap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator
// drives alloc and free items into the heap allocator under several idling
// phases and chunk sizes; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator;
  import bta_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CHUNK_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [REQ_W-1:0]   req_size;
  logic [ADDR_W-1:0]  block_addr;
  logic               out_valid;
  logic               out_stall;
  logic [ADDR_W-1:0]  result_addr;
  logic [STAT_W-1:0]  status;
  int                 fail_count;
  int                 pending;

  // idling knobs, percent of cycles
  int  send_idle_pct;
  int  stall_pct;
  int  hold_cycles;      // long receiver hold-off, counted by the stall process
  int  cycle_count;
  // payloads handed out by alloc results, candidates for free
  logic [ADDR_W-1:0] live_blocks[$];

  boundary_tag_heap_allocator i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .cmd, .req_size,
    .block_addr, .out_valid, .out_stall, .result_addr, .status
  );

  heap_alloc_checker i_checker (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .cmd, .req_size,
    .block_addr, .out_valid, .out_stall, .result_addr, .status, .fail_count,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // timeout guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("tb_boundary_tag_heap_allocator: FAIL");
        $finish;
      end
    end
  end

  // receiver stall: random, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // remember allocated payloads so frees mostly hit real blocks
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && status == ST_OK && result_addr != 0)
      live_blocks.push_back(result_addr);
  end

  // one item, held until accepted; valid stays up when another follows
  task automatic send(logic c, logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] ba);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    req_size   <= rq;
    block_addr <= ba;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let the block settle
    repeat (200) @(posedge clk);
  endtask

  task automatic set_chunk(logic [CHUNK_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly small requests, some big ones, frees of live and random addresses
  task automatic random_item();
    int k, r;
    logic [REQ_W-1:0] rq;
    r = $urandom_range(99);
    if (r < 45) begin
      rq = (($urandom_range(9) == 0) ? REQ_W'($urandom()) : REQ_W'($urandom_range(200)));
      send(CMD_ALLOC, rq, REQ_W'($urandom()));
    end else if (r < 88 && live_blocks.size() != 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      send(CMD_FREE, REQ_W'($urandom()), live_blocks[k]);
      live_blocks.delete(k);
    end else begin
      send(CMD_FREE, REQ_W'($urandom()), ADDR_W'($urandom()));
    end
  endtask

  initial begin
    int ph;
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    cmd = CMD_ALLOC; req_size = '0; block_addr = '0;
    send_idle_pct = 0; stall_pct = 0; hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: free before init, zero size, field extremes, double free
    send(CMD_FREE, 16'hFFFF, 16'd8);
    send(CMD_ALLOC, 16'd0, 16'hFFFF);
    send(CMD_ALLOC, 16'd1, 16'd0);
    send(CMD_ALLOC, 16'd8, 16'd0);
    send(CMD_ALLOC, 16'd9, 16'd0);
    send(CMD_ALLOC, 16'd4000, 16'd0);
    send(CMD_ALLOC, 16'hFFFF, 16'd0);
    send(CMD_ALLOC, 16'd30000, 16'd0);
    send(CMD_ALLOC, 16'd30000, 16'd0);
    send(CMD_ALLOC, 16'd30000, 16'd0);
    go_quiet();
    send(CMD_FREE, 16'd0, 16'd16);
    send(CMD_FREE, 16'd0, 16'd16);
    send(CMD_FREE, 16'd0, 16'hFFFF);
    send(CMD_FREE, 16'd0, 16'd0);
    live_blocks.delete();
    go_quiet();

    // several chunk settings, extremes included; each pass runs one idling phase
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_chunk(17'd16);
        1: set_chunk(17'd65536);
        2: set_chunk(17'd13);
        3: set_chunk(17'h1FFFF);
        4: set_chunk(17'd0);
        default: set_chunk(17'd512);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      repeat (120) random_item();
      if (ph == 2) begin
        // long hold-off while items keep coming, so the block backs up
        stall_pct   = 0;
        hold_cycles = 400;
        repeat (20) random_item();
      end
      // free everything left so the next setting starts from an open heap
      while (live_blocks.size() != 0) send(CMD_FREE, 16'd0, live_blocks.pop_front());
      go_quiet();
    end

    send_idle_pct = 10; stall_pct = 10;
    repeat (600) random_item();
    go_quiet();

    if (fail_count == 0)
      $display("tb_boundary_tag_heap_allocator: PASS");
    else
      $display("tb_boundary_tag_heap_allocator: FAIL");
    $finish;
  end

endmodule
